// File: rtl/fwpt_pkg.sv
// Shared types, constants and helpers for the force window policy trigger.
// Depends on nothing; imported by force_window_policy_trigger.
`default_nettype none

package fwpt_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 8;
  localparam int BIN_W    = 3;
  localparam int ACT_W    = 2;
  localparam int TH_W     = 64;
  localparam int POLICY_W = 50;
  localparam int CFG_AW   = 2;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 32;

  // Defaults and fixed policy constants
  localparam int WINDOW_LEN_DEF = 8;
  localparam int BIN_COUNT      = 5;
  localparam int TABLE_STRIDE   = 5;
  localparam int TH_COUNT       = 4;

  localparam logic [PHASE_W-1:0] PHASE_LOW = 8'd50;
  localparam logic [PHASE_W-1:0] PHASE_END = 8'd80;

  // Reset values: thresholds -1.2, -0.9, -0.6, -0.3 in Q4.12, lowest first
  localparam logic [TH_W-1:0]     TH_RESET     = 64'd18101082249332714701;
  localparam logic [POLICY_W-1:0] POLICY_RESET = 50'd375321464771925;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SAMPLE_TH = 2'd0,
    CFG_MEAN_TH   = 2'd1,
    CFG_POLICY    = 2'd2
  } cfg_idx_t;

  // Request kinds
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ACK    = 1'b1
  } op_t;

  // Actions of interest
  localparam logic [ACT_W-1:0] ACT_INTERVENE = 2'd2;

  // Result request
  typedef struct packed {
    logic                       intervention_latched;
    logic                       new_intervention;
    logic                       action_valid;
    logic [ACT_W-1:0]           action;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [BIN_W-1:0]           mean_bin;
    logic [BIN_W-1:0]           sample_bin;
  } result_t;

  // First threshold the value is below, else the top bin
  function automatic logic [BIN_W-1:0] bin_of(
    input logic signed [SAMPLE_W-1:0] x,
    input logic [TH_W-1:0]            packed_th
  );
    logic [BIN_W-1:0]           res;
    logic signed [SAMPLE_W-1:0] th;
    res = BIN_W'(BIN_COUNT - 1);
    for (int k = TH_COUNT - 1; k >= 0; k--) begin
      th = packed_th[k*SAMPLE_W +: SAMPLE_W];
      if ((k < BIN_COUNT - 1) && (x < th)) begin
        res = BIN_W'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/force_window_policy_trigger.sv
// Force window policy trigger: moving-window mean, two binnings, policy lookup
// and sticky intervention latch. Depends on fwpt_pkg.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | in        | tdata: force_sample, flight_phase; tuser: op
//  out_    | out       | tdata: sample_bin .. intervention_latched
//  cfg_    | in        | write enable, register index, 64-bit data
//
// Each request passes stage 1 and then the output register; one request is
// taken every cycle while out_tready is high. The clock period is set by the
// constant-reciprocal multiply for the mean followed by the bin compares.
// Reset (rst_n low, synchronous) clears the window, sum, latch and valids and
// loads the default thresholds and policy table. A stall on out_tready holds
// both stages and drops in_tready once the pipeline is full.
`default_nettype none

module force_window_policy_trigger #(
  parameter int WINDOW_LEN = fwpt_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: [15:0] force_sample, [23:16] flight_phase
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [fwpt_pkg::IN_DW-1:0]    in_tdata,
  // in_tuser: [0] op
  input  wire logic                          in_tuser,
  // out_tdata: [2:0] sample_bin, [5:3] mean_bin, [21:6] window_mean,
  // [23:22] action, [24] action_valid, [25] new_intervention,
  // [26] intervention_latched, [31:27] zero
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [fwpt_pkg::OUT_DW-1:0]        out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [fwpt_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [fwpt_pkg::TH_W-1:0]     cfg_wdata
);
  import fwpt_pkg::*;

  localparam int WIN_LG = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + WIN_LG;
  localparam int MAG_W  = SUM_W;
  localparam int SHIFT  = MAG_W + WIN_LG;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [MAG_W:0] RECIP = RECIP_FULL[MAG_W:0];
  localparam logic signed [SUM_W:0] ROUND_ADJ = (SUM_W+1)'(WINDOW_LEN - 1);

  // Configuration registers
  logic [TH_W-1:0]     sample_th_r;
  logic [TH_W-1:0]     mean_th_r;
  logic [POLICY_W-1:0] policy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_th_r <= TH_RESET;
      mean_th_r   <= TH_RESET;
      policy_r    <= POLICY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SAMPLE_TH: sample_th_r <= cfg_wdata;
        CFG_MEAN_TH:   mean_th_r   <= cfg_wdata;
        CFG_POLICY:    policy_r    <= cfg_wdata[POLICY_W-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake and pipeline advance
  logic s1_v_r;
  logic out_adv;
  logic in_acc;

  assign out_adv   = !out_tvalid || out_tready;
  assign in_tready = !s1_v_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input field split
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [PHASE_W-1:0]         in_phase;
  op_t                        in_op;

  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_phase  = in_tdata[SAMPLE_W +: PHASE_W];
  assign in_op     = op_t'(in_tuser);

  // Sample window and running sum, updated on accept of a sample request
  logic signed [SAMPLE_W-1:0] win_r [WINDOW_LEN];
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;

  assign sum_nxt = sum_r - SUM_W'(win_r[WINDOW_LEN-1]) + SUM_W'(in_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (in_acc && in_op == OP_SAMPLE) begin
      win_r[0] <= in_sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

  // Stage 1 registers: request and the window sum it sees
  op_t                        s1_op_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [PHASE_W-1:0]         s1_phase_r;
  logic signed [SUM_W-1:0]    s1_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_op;
      s1_sample_r <= in_sample;
      s1_phase_r  <= in_phase;
      s1_sum_r    <= (in_op == OP_SAMPLE) ? sum_nxt : sum_r;
    end
  end

  // Floor mean: magnitude rounded up for negatives, reciprocal multiply
  logic                       sum_neg;
  logic signed [SUM_W:0]      mag_ext;
  logic [MAG_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_W-1:0]        quo;
  logic signed [SAMPLE_W-1:0] mean;

  assign sum_neg = s1_sum_r[SUM_W-1];
  assign mag_ext = sum_neg ? (-{s1_sum_r[SUM_W-1], s1_sum_r} + ROUND_ADJ)
                           : {s1_sum_r[SUM_W-1], s1_sum_r};
  assign mag     = mag_ext[MAG_W-1:0];
  assign prod    = PROD_W'(mag) * PROD_W'(RECIP);
  assign quo     = prod[SHIFT +: SAMPLE_W];
  assign mean    = sum_neg ? -quo : quo;

  // Binning, policy lookup and latch decision
  logic [BIN_W-1:0]  sbin;
  logic [BIN_W-1:0]  mbin;
  logic [4:0]        tbl_idx;
  logic [ACT_W-1:0]  act;
  logic              phase_ok;
  logic              latch_r;
  logic              latch_nxt;
  result_t           res;

  assign sbin     = bin_of(s1_sample_r, sample_th_r);
  assign mbin     = bin_of(mean, mean_th_r);
  assign tbl_idx  = 5'(sbin * TABLE_STRIDE) + 5'(mbin);
  assign act      = policy_r[2*tbl_idx +: ACT_W];
  assign phase_ok = (s1_phase_r >= PHASE_LOW) && (s1_phase_r < PHASE_END);

  always_comb begin
    res             = '0;
    res.window_mean = mean;
    latch_nxt       = latch_r;
    unique case (s1_op_r)
      OP_ACK: begin
        latch_nxt = 1'b0;
      end
      OP_SAMPLE: begin
        res.sample_bin   = sbin;
        res.mean_bin     = mbin;
        res.action       = act;
        res.action_valid = phase_ok;
        if (phase_ok && act == ACT_INTERVENE && !latch_r) begin
          latch_nxt            = 1'b1;
          res.new_intervention = 1'b1;
        end
      end
      default: ;
    endcase
    res.intervention_latched = latch_nxt;
  end

  // Output register and latch, both move when stage 1 hands over
  result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      latch_r    <= 1'b0;
    end else if (out_adv) begin
      out_tvalid <= s1_v_r;
      if (s1_v_r) begin
        latch_r <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      out_r <= res;
    end
  end

  assign out_tdata = OUT_DW'(out_r);

  // Checks
  a_new_means_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.new_intervention |->
      out_r.intervention_latched && out_r.action_valid
      && out_r.action == ACT_INTERVENE)
    else $error("new intervention without a valid intervene action");

  a_latch_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_r.intervention_latched == latch_r)
    else $error("reported latch differs from latch state");

  a_bins_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_r.sample_bin <= BIN_W'(BIN_COUNT - 1)
      && out_r.mean_bin <= BIN_W'(BIN_COUNT - 1))
    else $error("bin out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_adv |=> s1_v_r && $stable(s1_sum_r) && $stable(s1_sample_r))
    else $error("stage 1 request lost during stall");

endmodule

`default_nettype wire

// File: dv/force_window_policy_trigger_tb.sv
// Self-checking bench for force_window_policy_trigger: predicts every result request
// from its own window, binning and policy model and compares the stream field by field.
// Depends on fwpt_pkg and the force_window_policy_trigger RTL.
`timescale 1ns / 100ps

module force_window_policy_trigger_tb;
  import fwpt_pkg::*;

  localparam int WIN         = WINDOW_LEN_DEF;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [TH_W-1:0]     TH_ALL_MIN   = 64'h8000_8000_8000_8000;
  localparam logic [TH_W-1:0]     TH_ALL_MAX   = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [TH_W-1:0]     TH_ALL_ONES  = '1;
  localparam logic [POLICY_W-1:0] POL_ALL_INTV = 50'h2_AAAA_AAAA_AAAA;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]         phase;
  } force_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_addr = CFG_SAMPLE_TH;
  logic [TH_W-1:0]     cfg_wdata = '0;

  force_window_policy_trigger #(.WINDOW_LEN(WIN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Request and result stores
  force_req_t force_req_q[$];
  result_t    policy_results_due[$];
  force_req_t cur_req;
  int         reqs_in_flight = 0;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         force_level = 0;

  // Model copy of configuration and state
  logic [TH_W-1:0]            sample_th = TH_RESET;
  logic [TH_W-1:0]            mean_th = TH_RESET;
  logic [POLICY_W-1:0]        policy_tbl = POLICY_RESET;
  logic signed [SAMPLE_W-1:0] win_samples[WIN];
  int                         win_total = 0;
  bit                         latch_model = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // First threshold the value sits below, else the top bin
  function automatic logic [BIN_W-1:0] force_bin(logic signed [SAMPLE_W-1:0] x,
                                                  logic [TH_W-1:0] th);
    logic signed [SAMPLE_W-1:0] t;
    for (int k = 0; k < BIN_COUNT - 1 && k < TH_COUNT; k++) begin
      t = th[k*SAMPLE_W +: SAMPLE_W];
      if (x < t) return BIN_W'(k);
    end
    return BIN_W'(BIN_COUNT - 1);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] floor_mean(int total);
    int m;
    m = (total >= 0) ? total / WIN : -((-total + WIN - 1) / WIN);
    return SAMPLE_W'(m);
  endfunction

  // Advance the model by one accepted request and queue its result
  task automatic compute_policy_result(force_req_t r);
    result_t res;
    res = '0;
    if (r.op == OP_ACK) begin
      latch_model = 1'b0;
      res.window_mean = floor_mean(win_total);
    end else begin
      win_total -= win_samples[WIN-1];
      for (int i = WIN - 1; i > 0; i--) win_samples[i] = win_samples[i-1];
      win_samples[0] = r.sample;
      win_total += r.sample;
      res.window_mean  = floor_mean(win_total);
      res.sample_bin   = force_bin(r.sample, sample_th);
      res.mean_bin     = force_bin(res.window_mean, mean_th);
      res.action       = policy_tbl[2*(res.sample_bin*TABLE_STRIDE + res.mean_bin) +: 2];
      res.action_valid = (r.phase >= PHASE_LOW) && (r.phase < PHASE_END);
      if (res.action_valid && res.action == ACT_INTERVENE && !latch_model) begin
        latch_model = 1'b1;
        res.new_intervention = 1'b1;
      end
    end
    res.intervention_latched = latch_model;
    policy_results_due.push_back(res);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Driver: present the next pending request once the current one is taken
  always @(posedge clk) begin : drive_p
    force_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) compute_policy_result(cur_req);
      if (force_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = force_req_q.pop_front();
        cur_req   <= nxt;
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.phase, nxt.sample};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison
  always @(posedge clk) begin : watch_p
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (policy_results_due.size() == 0) begin
          $error("result with nothing expected: tdata %h", out_tdata);
          errors++;
        end else begin
          want = policy_results_due.pop_front();
          reqs_in_flight--;
          check_field("sample_bin", want.sample_bin, got.sample_bin);
          check_field("mean_bin", want.mean_bin, got.mean_bin);
          check_field("window_mean", int'(want.window_mean), int'(got.window_mean));
          check_field("action", want.action, got.action);
          check_field("action_valid", want.action_valid, got.action_valid);
          check_field("new_intervention", want.new_intervention, got.new_intervention);
          check_field("intervention_latched", want.intervention_latched,
                      got.intervention_latched);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("force_window_policy_trigger verification failed");
      $finish;
    end
  end

  // Register write; only called with nothing in flight
  task automatic write_reg(cfg_idx_t idx, logic [TH_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SAMPLE_TH: sample_th = val;
      CFG_MEAN_TH:   mean_th = val;
      CFG_POLICY:    policy_tbl = val[POLICY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (reqs_in_flight != 0) @(posedge clk);
  endtask

  task automatic push_req(op_t op, int sample, int phase);
    force_req_t r;
    r.op     = op;
    r.sample = SAMPLE_W'(sample);
    r.phase  = PHASE_W'(phase);
    force_req_q.push_back(r);
    reqs_in_flight++;
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // Four random thresholds in ascending order
  function automatic logic [TH_W-1:0] sorted_thresholds();
    int t[4];
    int tmp;
    logic [TH_W-1:0] packed_th;
    for (int i = 0; i < 4; i++) t[i] = int'($signed(16'($urandom)));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (t[j] > t[j+1]) begin
          tmp = t[j]; t[j] = t[j+1]; t[j+1] = tmp;
        end
    for (int i = 0; i < 4; i++) packed_th[16*i +: 16] = 16'(t[i]);
    return packed_th;
  endfunction

  // Random traffic: mostly samples that dwell around a level so the mean moves
  // through the bins, some near thresholds, some full-range noise and acks
  task automatic queue_random_reqs(int n);
    int sel, smp, phs, k;
    logic [TH_W-1:0] th;
    op_t op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) force_level = int'($signed(16'($urandom)));
      op  = ($urandom_range(9) == 0) ? OP_ACK : OP_SAMPLE;
      phs = ($urandom_range(1) != 0) ? $urandom_range(79, 50) : $urandom_range(255);
      sel = $urandom_range(9);
      if (sel < 3) begin
        smp = int'($signed(16'($urandom)));
      end else if (sel < 8) begin
        smp = clamp16(force_level + int'($urandom_range(4096)) - 2048);
      end else begin
        k   = $urandom_range(3);
        th  = ($urandom_range(1) != 0) ? sample_th : mean_th;
        smp = clamp16(int'($signed(th[16*k +: 16])) + int'($urandom_range(4)) - 2);
      end
      push_req(op, smp, phs);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic [TH_W-1:0] s_th,
                           logic [TH_W-1:0] m_th, logic [POLICY_W-1:0] pol, int n);
    write_reg(CFG_SAMPLE_TH, s_th);
    write_reg(CFG_MEAN_TH, m_th);
    write_reg(CFG_POLICY, TH_W'(pol));
    end_writes();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    // first half, then a full drain before the rest
    queue_random_reqs(n / 2);
    wait_idle();
    queue_random_reqs(n - n / 2);
    wait_idle();
  endtask

  initial begin : main_p
    logic [SAMPLE_W-1:0] th;
    for (int i = 0; i < WIN; i++) win_samples[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, phase edges, threshold boundaries, acks
    push_req(OP_SAMPLE, 0, 60);
    push_req(OP_SAMPLE, 32767, 50);
    push_req(OP_SAMPLE, -32768, 79);
    push_req(OP_SAMPLE, -32768, 49);
    push_req(OP_SAMPLE, 32767, 80);
    push_req(OP_SAMPLE, -1, 0);
    push_req(OP_SAMPLE, 1, 255);
    for (int k = 0; k < TH_COUNT; k++) begin
      th = sample_th[16*k +: 16];
      push_req(OP_SAMPLE, int'($signed(th - 16'd1)), 65);
      push_req(OP_SAMPLE, int'($signed(th)), 65);
    end
    push_req(OP_ACK, -32768, 60);
    push_req(OP_ACK, 32767, 0);
    wait_idle();

    // Every entry intervenes: set, already set, out of phase, clear, clear again, set again
    write_reg(CFG_POLICY, TH_W'(POL_ALL_INTV));
    end_writes();
    push_req(OP_SAMPLE, 100, 60);
    push_req(OP_SAMPLE, 100, 61);
    push_req(OP_SAMPLE, 5, 10);
    push_req(OP_ACK, 0, 60);
    push_req(OP_ACK, 0, 60);
    push_req(OP_SAMPLE, -7, 79);
    wait_idle();

    // Random phases across idling patterns and register settings
    run_phase(0, 0, sorted_thresholds(), sorted_thresholds(),
              POLICY_W'({$urandom, $urandom}), 72);
    run_phase(67, 0, TH_RESET, TH_ALL_MAX, POL_ALL_INTV, 72);
    run_phase(0, 67, TH_ALL_MIN, '0, POLICY_W'({$urandom, $urandom}), 72);
    run_phase(31, 31, TH_ALL_ONES, TH_ALL_MIN, '1, 72);
    run_phase(0, 0, '0, TH_RESET, '0, 72);
    run_phase(31, 31, {$urandom, $urandom}, {$urandom, $urandom},
              POLICY_W'({$urandom, $urandom}), 72);

    wait_idle();
    repeat (10) @(posedge clk);
    if (policy_results_due.size() != 0) begin
      $error("%0d results never arrived", policy_results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("force_window_policy_trigger verification clean");
    end else begin
      $display("force_window_policy_trigger verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fwpt_pkg.sv
rtl/force_window_policy_trigger.sv
dv/force_window_policy_trigger_tb.sv
